// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/fpalu_pkg.sv =====
package fpalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  localparam int unsigned FIELD_BITS = 32;

endpackage

// ===== hdl/fpalu_div.sv =====
`include "assert_macros.svh"

// Pipelined signed divider: restoring, one quotient bit per stage.
// Dividend is a * 2^FRAC_BITS (sign-magnitude), truncates toward zero.
// Operands are registered on entry, then step through the quotient stages; a new divide may enter every cycle.
module fpalu_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [WORD_BITS-1:0] in_a,
  input  logic [WORD_BITS-1:0] in_b,
  output logic                 out_vld,
  output logic [WORD_BITS-1:0] out_q
);
  localparam int DIV_STAGES = WORD_BITS + FRAC_BITS;
  localparam int NB = DIV_STAGES;

  logic          vld_r [DIV_STAGES+1];
  logic [NB-1:0] num_r [DIV_STAGES+1];   // dividend shifting out, quotient in
  logic [WORD_BITS-1:0] rem_r [DIV_STAGES+1];   // below the divisor whenever the divisor is nonzero
  logic [WORD_BITS-1:0] den_r [DIV_STAGES+1];
  logic          neg_r [DIV_STAGES+1];

  logic [WORD_BITS-1:0] mag_a, mag_b;
  assign mag_a = in_a[WORD_BITS-1] ? (~in_a + 1'b1) : in_a;
  assign mag_b = in_b[WORD_BITS-1] ? (~in_b + 1'b1) : in_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    num_r[0] <= {mag_a, {FRAC_BITS{1'b0}}};
    rem_r[0] <= '0;
    den_r[0] <= mag_b;
    neg_r[0] <= in_a[WORD_BITS-1] ^ in_b[WORD_BITS-1];
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [WORD_BITS+1:0] trial;
    logic [WORD_BITS:0]   sh;
    assign sh    = {rem_r[s], num_r[s][NB-1]};
    assign trial = {1'b0, sh} - {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      rem_r[s+1] <= trial[WORD_BITS+1] ? sh[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      num_r[s+1] <= {num_r[s][NB-2:0], ~trial[WORD_BITS+1]};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
    end
  end

  logic [WORD_BITS-1:0] q_mag;
  assign q_mag   = num_r[DIV_STAGES][WORD_BITS-1:0];
  assign out_vld = vld_r[DIV_STAGES];
  assign out_q   = neg_r[DIV_STAGES] ? (~q_mag + 1'b1) : q_mag;

  `ASSERT_CLK(a_div_lat, clk, rst_n, in_vld |-> ##(DIV_STAGES+1) out_vld,
    "divider lost an operation")
  `ASSERT_ALWAYS(a_div_rst, clk, !rst_n |=> !vld_r[0], "divider valid not cleared")
endmodule

// ===== hdl/fixed_point_alu_q24_8.sv =====
// Channel | ports                                        | handshake
// in      | in_op, in_operand_a, in_operand_b            | start & !busy
// out     | out_value, out_compare_true, out_divide_by_zero | out_valid, one cycle
//
// One item may enter every cycle; busy is held low. Every operation has the same
// latency from transfer to result, set by the divider: one restoring quotient
// bit per stage. Other ops ride a delay line alongside it, so results leave in
// order. Multiply: partial products on stage 1, sum and shift on 2. Reset clears
// only the valid bits. The receiver cannot stall.
`include "assert_macros.svh"

module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_op,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  output logic signed [31:0] out_value,
  output logic        out_compare_true,
  output logic        out_divide_by_zero
);
  localparam int W  = WORD_BITS;
  localparam int DS = WORD_BITS + FRAC_BITS;
  localparam int LAT = DS + 1;           // divider latency
  localparam int HW  = (W + 1) / 2;      // multiplier low half width
  localparam int UW  = W - HW;           // multiplier high half width

  assign busy = 1'b0;

  logic acc;
  assign acc = start & ~busy;

  // ---- stage 0: operand selection (low W bits), simple ops
  logic signed [W-1:0] a, b;
  assign a = in_operand_a[W-1:0];
  assign b = in_operand_b[W-1:0];

  fpalu_pkg::op_t op;
  assign op = fpalu_pkg::op_t'(in_op);

  logic [W-1:0] simple;
  logic         cmp, dz, is_mul, is_div;
  always_comb begin
    simple = '0;
    cmp    = 1'b0;
    dz     = 1'b0;
    is_mul = 1'b0;
    is_div = 1'b0;
    case (op)
      fpalu_pkg::OP_ADD:      simple = a + b;
      fpalu_pkg::OP_SUB:      simple = a - b;
      fpalu_pkg::OP_MUL:      is_mul = 1'b1;
      fpalu_pkg::OP_DIV: begin
        is_div = (b != '0);
        dz     = (b == '0);
      end
      fpalu_pkg::OP_GT:       cmp = a > b;
      fpalu_pkg::OP_LT:       cmp = a < b;
      fpalu_pkg::OP_GE:       cmp = a >= b;
      fpalu_pkg::OP_LE:       cmp = a <= b;
      fpalu_pkg::OP_EQ:       cmp = a == b;
      fpalu_pkg::OP_NE:       cmp = a != b;
      fpalu_pkg::OP_INC:      simple = a + 1'b1;
      fpalu_pkg::OP_DEC:      simple = a - 1'b1;
      fpalu_pkg::OP_MIN:      simple = (a < b) ? a : b;
      fpalu_pkg::OP_MAX:      simple = (a > b) ? a : b;
      fpalu_pkg::OP_FROM_INT: simple = a << FRAC_BITS;
      fpalu_pkg::OP_TO_INT:   simple = a >>> FRAC_BITS;
      default:                simple = '0;
    endcase
  end

  // ---- multiply: stage 1 partial products, stage 2 sum and shift
  // Low halves are unsigned (zero-extended), high halves carry the sign.
  logic signed [HW:0]   a_lo, b_lo;
  logic signed [UW-1:0] a_hi, b_hi;
  assign a_lo = {1'b0, a[HW-1:0]};
  assign b_lo = {1'b0, b[HW-1:0]};
  assign a_hi = a[W-1:HW];
  assign b_hi = b[W-1:HW];

  logic signed [2*HW+1:0] p_ll;
  logic signed [HW+UW:0]  p_lh, p_hl;
  logic signed [2*UW-1:0] p_hh;
  assign p_ll = a_lo * b_lo;
  assign p_lh = a_lo * b_hi;
  assign p_hl = a_hi * b_lo;
  assign p_hh = a_hi * b_hi;

  logic signed [2*W-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  always_ff @(posedge clk) begin
    pp_ll_r <= (2*W)'(p_ll);
    pp_lh_r <= (2*W)'(p_lh);
    pp_hl_r <= (2*W)'(p_hl);
    pp_hh_r <= (2*W)'(p_hh);
  end
  logic signed [2*W-1:0] prod;
  assign prod = pp_ll_r + (pp_lh_r <<< HW) + (pp_hl_r <<< HW) + (pp_hh_r <<< (2*HW));
  logic [W-1:0] mul_r;
  always_ff @(posedge clk) begin
    mul_r <= prod[FRAC_BITS +: W];
  end

  // ---- divider
  logic         dv_vld;
  logic [W-1:0] dv_q;
  fpalu_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .in_vld(acc & is_div), .in_a(a), .in_b(b),
    .out_vld(dv_vld), .out_q(dv_q)
  );

  // ---- delay line carrying valid and non-divide results
  typedef struct packed {
    logic         vld;
    logic         mul;
    logic         div;
    logic         cmp;
    logic         dz;
    logic [W-1:0] val;
  } tag_t;

  tag_t line_r [LAT];
  tag_t t0;
  always_comb begin
    t0     = '0;
    t0.vld = acc;
    t0.mul = is_mul;
    t0.div = is_div;
    t0.cmp = cmp;
    t0.dz  = dz;
    t0.val = simple;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) line_r[i].vld <= 1'b0;
    end else begin
      line_r[0].vld <= t0.vld;
      for (int i = 1; i < LAT; i++) line_r[i].vld <= line_r[i-1].vld;
    end
    line_r[0].mul <= t0.mul;
    line_r[0].div <= t0.div;
    line_r[0].cmp <= t0.cmp;
    line_r[0].dz  <= t0.dz;
    line_r[0].val <= t0.val;
    line_r[1].mul <= line_r[0].mul;
    line_r[1].div <= line_r[0].div;
    line_r[1].cmp <= line_r[0].cmp;
    line_r[1].dz  <= line_r[0].dz;
    line_r[1].val <= line_r[0].val;
    // product from mul_r is merged into this entry
    line_r[2].mul <= line_r[1].mul;
    line_r[2].div <= line_r[1].div;
    line_r[2].cmp <= line_r[1].cmp;
    line_r[2].dz  <= line_r[1].dz;
    line_r[2].val <= line_r[1].mul ? mul_r : line_r[1].val;
    for (int i = 3; i < LAT; i++) begin
      line_r[i].mul <= line_r[i-1].mul;
      line_r[i].div <= line_r[i-1].div;
      line_r[i].cmp <= line_r[i-1].cmp;
      line_r[i].dz  <= line_r[i-1].dz;
      line_r[i].val <= line_r[i-1].val;
    end
  end

  // ---- output register
  logic         out_valid_r, cmp_r, dz_r;
  logic [W-1:0] val_r;
  tag_t         tl;
  assign tl = line_r[LAT-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tl.vld;
    end
    val_r <= tl.div ? dv_q : tl.val;
    cmp_r <= tl.cmp;
    dz_r  <= tl.dz;
  end

  assign out_valid          = out_valid_r;
  assign out_value          = 32'(signed'(val_r));
  assign out_compare_true   = cmp_r;
  assign out_divide_by_zero = dz_r;

  `ASSERT_CLK(a_div_align, clk, rst_n, (tl.vld && tl.div) == dv_vld,
    "divider result out of step with delay line")
  `ASSERT_CLK(a_flags_excl, clk, rst_n, !(out_valid && out_compare_true && out_divide_by_zero),
    "compare and divide-by-zero both set")
  `ASSERT_CLK(a_dz_zero, clk, rst_n, (out_valid && out_divide_by_zero) |-> out_value == '0,
    "divide by zero with nonzero value")
endmodule
